>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Wrappers for concurrent checks. They expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check on every rising edge, ignored while reset is asserted.
`define LPL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check on every rising edge, reset included.
`define LPL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define LPL_ASSERT(lbl, clk, rstn, prop, msg)
`define LPL_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/core/lpl_pkg.sv
// ----------------------------------------------------------------------------
// Look-ahead peak limiter package
// Widths, constants, register indexes and shared types of the limiter.
// ----------------------------------------------------------------------------
package lpl_pkg;

  // Field widths.
  localparam int SMP_W     = 24;  // input sample, Q1.23 signed
  localparam int OUT_W     = 25;  // output sample, Q2.23 signed
  localparam int GAIN_W    = 24;  // envelope gain, Q1.23 unsigned
  localparam int IGAIN_W   = 16;  // input gain, Q4.12 unsigned
  localparam int COEF_W    = 24;  // smoothing coefficient, Q0.24
  localparam int CEIL_W    = 24;  // ceiling, Q1.23 unsigned
  localparam int DLEN_W    = 10;  // look-ahead length field
  localparam int SCL_W     = 28;  // gain-scaled sample

  // Stream and configuration port widths.
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * OUT_W - GAIN_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  // Look-ahead memory.
  localparam int MAX_DELAY = 512;
  localparam int ADDR_W    = $clog2(MAX_DELAY);
  localparam int FILL_W    = ADDR_W + 1;

  // Serial step counts.
  localparam int IGAIN_FRAC  = 12;
  localparam int SCALE_STEPS = IGAIN_W;
  localparam int SCALE_LOW   = SCALE_STEPS - IGAIN_FRAC;
  localparam int OUT_STEPS   = GAIN_W;
  localparam int ENV_STEPS   = COEF_W;
  localparam int QUO_W       = 23;
  localparam int CNT_W       = 5;

  // Gain and ceiling limits.
  localparam logic [GAIN_W-1:0]  UNITY_GAIN = 24'd8388608;
  localparam logic [CEIL_W-1:0]  CEIL_MIN   = 24'd2107246;
  localparam logic [CEIL_W-1:0]  CEIL_MAX   = 24'd8388608;
  localparam logic [COEF_W:0]    COEF_ONE   = 25'd16777216;

  // Register reset values.
  localparam logic                RST_ENABLE    = 1'b1;
  localparam logic [CEIL_W-1:0]   RST_CEILING   = 24'd8388608;
  localparam logic [IGAIN_W-1:0]  RST_IN_GAIN   = 16'd4096;
  localparam logic [COEF_W-1:0]   RST_ATTACK    = 24'd16431307;
  localparam logic [COEF_W-1:0]   RST_RELEASE   = 24'd16773721;
  localparam logic [DLEN_W-1:0]   RST_DELAY_LEN = 10'd480;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE      = 3'd0,
    REG_CEILING     = 3'd1,
    REG_INPUT_GAIN  = 3'd2,
    REG_ATTACK      = 3'd3,
    REG_RELEASE     = 3'd4,
    REG_DELAY_LEN   = 3'd5
  } reg_idx_t;

  // Sequencer states.
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCALE = 7'b0000010,
    ST_PEAK  = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_ENV   = 7'b0010000,
    ST_MUL   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  // Control of one serial multiplier lane.
  typedef struct packed {
    logic clr;   // load the parallel operand, clear the accumulator
    logic step;  // take one multiplier bit
    logic mbit;  // current multiplier bit, LSB first
  } lane_ctl_t;

  // Access request to the look-ahead memory.
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
  } dly_req_t;

endpackage

>>> rtl/core/lpl_lane.sv
// ----------------------------------------------------------------------------
// Serial multiplier lane
// Shift-add multiplier: a parallel operand times a multiplier taken one bit
// per cycle on step high, LSB first. Low product bits go to a shift register.
// ----------------------------------------------------------------------------
module lpl_lane (
  input  logic                                clk,
  input  lpl_pkg::lane_ctl_t                  ctl,
  input  logic [lpl_pkg::SCL_W-1:0]           a_in,
  output logic [lpl_pkg::SCL_W-1:0]           acc,
  output logic [lpl_pkg::OUT_STEPS-1:0]       low
);
  import lpl_pkg::*;

  logic [SCL_W-1:0]     a_r;
  logic [SCL_W-1:0]     acc_r;
  logic [OUT_STEPS-1:0] low_r;
  logic [SCL_W:0]       sum;

  // Partial sum of this step; the accumulator stays below the operand.
  assign sum = {1'b0, acc_r} + (ctl.mbit ? {1'b0, a_r} : '0);

  // Accumulate and shift right, the dropped bit enters the low register.
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      a_r   <= a_in;
      acc_r <= '0;
      low_r <= '0;
    end else if (ctl.step) begin
      acc_r <= sum[SCL_W:1];
      low_r <= {sum[0], low_r[OUT_STEPS-1:1]};
    end
  end

  assign acc = acc_r;
  assign low = low_r;

endmodule

>>> rtl/core/lpl_divider.sv
// ----------------------------------------------------------------------------
// Serial target-gain divider
// Restoring divider, one quotient bit per cycle: ceiling * 2^23 / peak for
// a peak above the ceiling, so the quotient stays below unity.
// ----------------------------------------------------------------------------
module lpl_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lpl_pkg::CEIL_W-1:0]    dividend,
  input  logic [lpl_pkg::SCL_W-1:0]     divisor,
  output logic [lpl_pkg::QUO_W-1:0]     quo,
  output logic                          done
);
  import lpl_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SCL_W-1:0] rem_r;
  logic [SCL_W-1:0] div_r;
  logic [QUO_W-1:0] quo_r;
  logic [SCL_W:0]   trial;
  logic [SCL_W+1:0] diff;
  logic             ge;

  // The remainder always stays below the divisor; the next dividend bits are zero.
  assign trial = {rem_r, 1'b0};
  assign diff  = {1'b0, trial} - {2'b00, div_r};
  assign ge    = ~diff[SCL_W+1];

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= SCL_W'(dividend);
      div_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[SCL_W-1:0] : trial[SCL_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

>>> rtl/core/lpl_envelope.sv
// ----------------------------------------------------------------------------
// Envelope smoother
// Holds the envelope gain and moves it toward a target:
// (env * c + target * (2^24 - c)) / 2^24, both bit-serial over coefficients.
// ----------------------------------------------------------------------------
module lpl_envelope (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lpl_pkg::GAIN_W-1:0]    target,
  input  logic [lpl_pkg::COEF_W-1:0]    atk_coef,
  input  logic [lpl_pkg::COEF_W-1:0]    rel_coef,
  output logic [lpl_pkg::GAIN_W-1:0]    gain,
  output logic                          done
);
  import lpl_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [GAIN_W-1:0] env_r;
  logic [GAIN_W-1:0] tgt_r;
  logic [COEF_W-1:0] c_sr_r;
  logic [COEF_W:0]   d_sr_r;
  logic [GAIN_W:0]   acc_r;
  logic              sticky_r;
  logic              up_r;
  logic              atk_sel;
  logic [COEF_W-1:0] coef;
  logic [GAIN_W+1:0] sum;
  logic [GAIN_W+1:0] fin;

  // Attack when the target lies below the envelope.
  assign atk_sel = target < env_r;
  assign coef    = atk_sel ? atk_coef : rel_coef;

  // One bit of both coefficients per step.
  assign sum = {1'b0, acc_r}
             + (c_sr_r[0] ? {2'b00, env_r} : '0)
             + (d_sr_r[0] ? {2'b00, tgt_r} : '0);

  // Top bit of 2^24 - c, then round up on release when any low bit was set.
  assign fin = {1'b0, acc_r}
             + (d_sr_r[0] ? {2'b00, tgt_r} : '0)
             + (GAIN_W + 2)'(up_r & sticky_r);

  // Control and envelope state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      env_r  <= UNITY_GAIN;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ENV_STEPS)) begin
          env_r  <= fin[GAIN_W-1:0];
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Serial product datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      tgt_r    <= target;
      c_sr_r   <= coef;
      d_sr_r   <= COEF_ONE - {1'b0, coef};
      acc_r    <= '0;
      sticky_r <= 1'b0;
      up_r     <= ~atk_sel;
    end else if (busy_r && (cnt_r != CNT_W'(ENV_STEPS))) begin
      acc_r    <= sum[GAIN_W+1:1];
      sticky_r <= sticky_r | sum[0];
      c_sr_r   <= {1'b0, c_sr_r[COEF_W-1:1]};
      d_sr_r   <= {1'b0, d_sr_r[COEF_W:1]};
    end
  end

  assign gain = env_r;
  assign done = done_r;

endmodule

>>> rtl/core/lpl_delay_line.sv
// ----------------------------------------------------------------------------
// Look-ahead delay line
// Two single-port memories of gain-scaled samples. A fill count marks the
// entries written since reset; entries beyond it read as zero.
// ----------------------------------------------------------------------------
module lpl_delay_line (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lpl_pkg::dly_req_t             req,
  input  logic [lpl_pkg::SCL_W-1:0]     wr_l,
  input  logic [lpl_pkg::SCL_W-1:0]     wr_r,
  output logic [lpl_pkg::SCL_W-1:0]     rd_l,
  output logic [lpl_pkg::SCL_W-1:0]     rd_r
);
  import lpl_pkg::*;

  logic [SCL_W-1:0]  mem_l [MAX_DELAY];
  logic [SCL_W-1:0]  mem_r [MAX_DELAY];
  logic [SCL_W-1:0]  rd_l_q;
  logic [SCL_W-1:0]  rd_r_q;
  logic              rd_ok_r;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] addr_ext;

  assign addr_ext = {1'b0, req.addr};

  // Memory ports, read data registered.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_l_q <= mem_l[req.addr];
      rd_r_q <= mem_r[req.addr];
    end
    if (req.wr_en) begin
      mem_l[req.addr] <= wr_l;
      mem_r[req.addr] <= wr_r;
    end
  end

  // Writes advance one entry at a time from zero, so the written entries
  // always form a prefix of the memory.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (req.rd_en) begin
        rd_ok_r <= addr_ext < fill_r;
      end
      if (req.wr_en && (addr_ext >= fill_r)) begin
        fill_r <= addr_ext + 1'b1;
      end
    end
  end

  assign rd_l = rd_ok_r ? rd_l_q : '0;
  assign rd_r = rd_ok_r ? rd_r_q : '0;

endmodule

>>> rtl/core/lookahead_peak_limiter_top.sv
// ----------------------------------------------------------------------------
// Look-ahead peak limiter, top level
// Stereo limiter: input gain, peak detection, target gain, envelope smoothing,
// look-ahead delay and output clamping, one sample pair per request.
// ----------------------------------------------------------------------------
// One stereo pair is processed at a time by a sequencer over bit-serial
// units: a 16-bit input-gain multiply, peak detection, a divider with a
// 23-bit quotient when the gain-scaled peak exceeds the ceiling, the envelope
// update and a 24-bit output multiply; while disabled the pair passes straight
// to the output register. The next pair is accepted while the previous result
// still waits in the output register. The look-ahead memory needs no
// clearing pass after reset. Configuration is written through the cfg
// port, which is always ready; the user must write it only while no request
// is in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lookahead_peak_limiter_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: left_in [23:0], right_in [47:24]
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [lpl_pkg::IN_TDATA_W-1:0]       in_tdata,
  // out_tdata: left_out [24:0], right_out [49:25], gain_now [73:50], zero pad
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [lpl_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lpl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lpl_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import lpl_pkg::*;

  // Magnitude of a two's complement sample.
  function automatic logic [SMP_W-1:0] mag_smp(input logic [SMP_W-1:0] x);
    return x[SMP_W-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic [SCL_W-1:0] mag_scl(input logic [SCL_W-1:0] x);
    return x[SCL_W-1] ? (~x + 1'b1) : x;
  endfunction

  // Rounded, clamped and signed output sample from a lane result.
  function automatic logic [OUT_W-1:0] limit(input logic [SCL_W-1:0]     acc,
                                             input logic [OUT_STEPS-1:0] low,
                                             input logic                 neg,
                                             input logic [CEIL_W-1:0]    ceil);
    logic [SCL_W+1:0]  m;
    logic [CEIL_W-1:0] mc;
    logic [OUT_W-1:0]  mo;
    m  = {1'b0, acc, low[OUT_STEPS-1]} + (SCL_W + 2)'(low[OUT_STEPS-2]);
    mc = (m > (SCL_W + 2)'(ceil)) ? ceil : m[CEIL_W-1:0];
    mo = {1'b0, mc};
    return neg ? (~mo + 1'b1) : mo;
  endfunction

  // Configuration registers.
  logic                enable_r;
  logic [CEIL_W-1:0]   ceiling_r;
  logic [IGAIN_W-1:0]  in_gain_r;
  logic [COEF_W-1:0]   attack_r;
  logic [COEF_W-1:0]   release_r;
  logic [DLEN_W-1:0]   delay_len_r;

  // Sequencer and datapath.
  state_t              state_r;
  state_t              state_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [GAIN_W-1:0]   mul_sr_r;
  logic [SMP_W-1:0]    in_l_r;
  logic [SMP_W-1:0]    in_r_r;
  logic                pass_r;
  logic [ADDR_W-1:0]   pos_r;
  logic [ADDR_W-1:0]   pos_nxt;
  logic [FILL_W-1:0]   pos_inc;
  logic [FILL_W-1:0]   len_eff;
  logic [CEIL_W-1:0]   ceil_eff;
  logic                in_req;
  logic                out_free;

  // Output register.
  logic                    out_tvalid_r;
  logic [OUT_TDATA_W-1:0]  out_tdata_r;
  logic [OUT_W-1:0]        res_l;
  logic [OUT_W-1:0]        res_r;

  // Unit connections.
  lane_ctl_t           lane_ctl;
  logic [SCL_W-1:0]    lane_a_l;
  logic [SCL_W-1:0]    lane_a_r;
  logic [SCL_W-1:0]    acc_l;
  logic [SCL_W-1:0]    acc_r;
  logic [OUT_STEPS-1:0] low_l;
  logic [OUT_STEPS-1:0] low_r;
  logic [SCL_W-1:0]    scl_l;
  logic [SCL_W-1:0]    scl_r;
  logic [SCL_W-1:0]    peak;
  logic                over;
  dly_req_t            dly_req;
  logic [SCL_W-1:0]    wr_l;
  logic [SCL_W-1:0]    wr_r;
  logic [SCL_W-1:0]    rd_l;
  logic [SCL_W-1:0]    rd_r;
  logic                div_start;
  logic [QUO_W-1:0]    div_quo;
  logic                div_done;
  logic                env_start;
  logic [GAIN_W-1:0]   env_target;
  logic [GAIN_W-1:0]   env_gain;
  logic                env_done;

  // Configuration writes; indexes beyond the list are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= RST_ENABLE;
      ceiling_r   <= RST_CEILING;
      in_gain_r   <= RST_IN_GAIN;
      attack_r    <= RST_ATTACK;
      release_r   <= RST_RELEASE;
      delay_len_r <= RST_DELAY_LEN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ENABLE:     enable_r    <= cfg_data[0];
        REG_CEILING:    ceiling_r   <= cfg_data[CEIL_W-1:0];
        REG_INPUT_GAIN: in_gain_r   <= cfg_data[IGAIN_W-1:0];
        REG_ATTACK:     attack_r    <= cfg_data[COEF_W-1:0];
        REG_RELEASE:    release_r   <= cfg_data[COEF_W-1:0];
        REG_DELAY_LEN:  delay_len_r <= cfg_data[DLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective ceiling and look-ahead length, saturated to their ranges.
  always_comb begin
    if (ceiling_r < CEIL_MIN) begin
      ceil_eff = CEIL_MIN;
    end else if (ceiling_r > CEIL_MAX) begin
      ceil_eff = CEIL_MAX;
    end else begin
      ceil_eff = ceiling_r;
    end
  end

  always_comb begin
    if (32'(delay_len_r) > MAX_DELAY) begin
      len_eff = FILL_W'(MAX_DELAY);
    end else if (delay_len_r == '0) begin
      len_eff = FILL_W'(1);
    end else begin
      len_eff = FILL_W'(delay_len_r);
    end
  end

  // Write position wraps when its successor reaches the length.
  assign pos_inc = {1'b0, pos_r} + 1'b1;
  assign pos_nxt = (pos_inc >= len_eff) ? '0 : pos_inc[ADDR_W-1:0];

  // Handshakes.
  assign in_tready = (state_r == ST_IDLE);
  assign in_req    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // Gain-scaled magnitudes: product >> 12 taken from the lane result.
  assign scl_l = {acc_l[SCL_W-SCALE_LOW-1:0], low_l[OUT_STEPS-1 -: SCALE_LOW]};
  assign scl_r = {acc_r[SCL_W-SCALE_LOW-1:0], low_r[OUT_STEPS-1 -: SCALE_LOW]};
  assign peak  = (scl_l > scl_r) ? scl_l : scl_r;
  assign over  = peak > SCL_W'(ceil_eff);

  // Signed values stored in the look-ahead line.
  assign wr_l = in_l_r[SMP_W-1] ? (~scl_l + 1'b1) : scl_l;
  assign wr_r = in_r_r[SMP_W-1] ? (~scl_r + 1'b1) : scl_r;

  // Lane operands: input magnitudes first, delayed magnitudes later.
  assign lane_a_l = (state_r == ST_IDLE) ? SCL_W'(mag_smp(in_tdata[SMP_W-1:0]))
                                         : mag_scl(rd_l);
  assign lane_a_r = (state_r == ST_IDLE) ? SCL_W'(mag_smp(in_tdata[2*SMP_W-1:SMP_W]))
                                         : mag_scl(rd_r);

  assign lane_ctl.clr  = (in_req && enable_r) || ((state_r == ST_ENV) && env_done);
  assign lane_ctl.step = (state_r == ST_SCALE) || (state_r == ST_MUL);
  assign lane_ctl.mbit = mul_sr_r[0];

  // Memory: read at acceptance, write back once the scaled pair is known.
  assign dly_req.rd_en = in_req && enable_r;
  assign dly_req.wr_en = (state_r == ST_PEAK);
  assign dly_req.addr  = pos_r;

  // Divider and envelope starts.
  assign div_start  = (state_r == ST_PEAK) && over;
  assign env_start  = ((state_r == ST_PEAK) && !over) || ((state_r == ST_DIV) && div_done);
  assign env_target = (state_r == ST_DIV) ? GAIN_W'(div_quo) : UNITY_GAIN;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_req) begin
          state_nxt = enable_r ? ST_SCALE : ST_DONE;
        end
      end
      ST_SCALE: begin
        if (cnt_r == CNT_W'(SCALE_STEPS - 1)) begin
          state_nxt = ST_PEAK;
        end
      end
      ST_PEAK: begin
        state_nxt = over ? ST_DIV : ST_ENV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_ENV;
        end
      end
      ST_ENV: begin
        if (env_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt_r == CNT_W'(OUT_STEPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (lane_ctl.step) begin
        cnt_r <= cnt_r + 1'b1;
      end else begin
        cnt_r <= '0;
      end
      if (state_r == ST_PEAK) begin
        pos_r <= pos_nxt;
      end
    end
  end

  // Request capture and multiplier bit shift register.
  always_ff @(posedge clk) begin
    if (in_req) begin
      in_l_r   <= in_tdata[SMP_W-1:0];
      in_r_r   <= in_tdata[2*SMP_W-1:SMP_W];
      pass_r   <= !enable_r;
      mul_sr_r <= GAIN_W'(in_gain_r);
    end else if ((state_r == ST_ENV) && env_done) begin
      mul_sr_r <= env_gain;
    end else if (lane_ctl.step) begin
      mul_sr_r <= {1'b0, mul_sr_r[GAIN_W-1:1]};
    end
  end

  // Result samples: pass-through while disabled, limited otherwise.
  assign res_l = pass_r ? {in_l_r[SMP_W-1], in_l_r}
                        : limit(acc_l, low_l, rd_l[SCL_W-1], ceil_eff);
  assign res_r = pass_r ? {in_r_r[SMP_W-1], in_r_r}
                        : limit(acc_r, low_r, rd_r[SCL_W-1], ceil_eff);

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      out_tdata_r <= {{OUT_PAD_W{1'b0}}, env_gain, res_r, res_l};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Serial units.
  lpl_lane u_lane_l (
    .clk  (clk),
    .ctl  (lane_ctl),
    .a_in (lane_a_l),
    .acc  (acc_l),
    .low  (low_l)
  );

  lpl_lane u_lane_r (
    .clk  (clk),
    .ctl  (lane_ctl),
    .a_in (lane_a_r),
    .acc  (acc_r),
    .low  (low_r)
  );

  lpl_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ceil_eff),
    .divisor  (peak),
    .quo      (div_quo),
    .done     (div_done)
  );

  lpl_envelope u_envelope (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (env_start),
    .target   (env_target),
    .atk_coef (attack_r),
    .rel_coef (release_r),
    .gain     (env_gain),
    .done     (env_done)
  );

  lpl_delay_line u_delay_line (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dly_req),
    .wr_l  (wr_l),
    .wr_r  (wr_r),
    .rd_l  (rd_l),
    .rd_r  (rd_r)
  );

  // Checks.
  `LPL_ASSERT(a_one_in_flight, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready, "request accepted while another is in flight")
  `LPL_ASSERT(a_div_in_state, clk, rst_n, div_done |-> (state_r == ST_DIV), "divider finished outside its state")
  `LPL_ASSERT(a_env_in_state, clk, rst_n, env_done |-> (state_r == ST_ENV), "envelope update finished outside its state")
  `LPL_ASSERT(a_gain_range, clk, rst_n, env_gain <= UNITY_GAIN, "envelope gain above unity")

endmodule
